// ===== hw/rtl/dest_pkg.sv =====
// ----------------------------------------------------------------------------
// dest_pkg
// Shared types and constants of the dual encoder speed and tick target block.
// ----------------------------------------------------------------------------
package dest_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PprW  = 8;
  localparam int unsigned DivW  = DataW + PprW;

  // register reset values
  localparam logic [DataW-1:0] TargetTicksRst    = 32'd0;
  localparam logic [DataW-1:0] StallLimitRst     = 32'd6000000;
  localparam logic [DataW-1:0] TicksPerMinuteRst = 32'd2400000000;
  localparam logic [PprW-1:0]  PulsesPerRevRst   = 8'd28;

  typedef enum logic [1:0] {
    KIND_RIGHT   = 2'd0,
    KIND_LEFT    = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_EMIT = 2'd3
  } back_state_e;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] timestamp;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [DataW-1:0] target_ticks;
    logic [DataW-1:0] stall_limit;
    logic [DataW-1:0] ticks_per_minute;
    logic [PprW-1:0]  pulses_per_rev;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [DataW-1:0] period_right;
    logic [DataW-1:0] period_left;
    logic [DataW-1:0] rpm_right;
    logic [DataW-1:0] rpm_left;
    logic [DataW-1:0] tick_average;
    logic             target_reached;
  } result_t;

endpackage

// ===== hw/rtl/dest_front.sv =====
// ----------------------------------------------------------------------------
// dest_front
// Input stage: registers each incoming item, decodes its action and hands it
// to the item queue.
// ----------------------------------------------------------------------------
module dest_front import dest_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [DataW-1:0] timestamp_i,
  input  fifo_stat_t       fifo_stat_i,
  output logic             push_o,
  output item_t            push_item_o
);

  localparam logic [1:0] ActRight   = 2'd0;
  localparam logic [1:0] ActLeft    = 2'd1;
  localparam logic [1:0] ActQuery   = 2'd2;
  localparam logic [1:0] ActRestart = 2'd3;

  logic  hold_valid_q, hold_valid_d;
  item_t hold_item_q;
  kind_e kind;
  logic  accept;

  always_comb begin
    case (action_i)
      ActRight:   kind = KIND_RIGHT;
      ActLeft:    kind = KIND_LEFT;
      ActQuery:   kind = KIND_QUERY;
      ActRestart: kind = KIND_RESTART;
      default:    kind = KIND_QUERY;
    endcase
  end

  assign in_stall_o   = hold_valid_q & fifo_stat_i.full;
  assign accept       = in_valid_i & ~in_stall_o;
  assign push_o       = hold_valid_q & ~fifo_stat_i.full;
  assign push_item_o  = hold_item_q;
  assign hold_valid_d = accept | (hold_valid_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_item_q <= '{kind: kind, timestamp: timestamp_i};
    end
  end

endmodule

// ===== hw/rtl/dest_fifo.sv =====
// ----------------------------------------------------------------------------
// dest_fifo
// Two entry item queue between the input stage and the execution stage.
// ----------------------------------------------------------------------------
module dest_fifo import dest_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      push_item_i,
  input  logic       pop_i,
  output item_t      pop_item_o,
  output fifo_stat_t stat_o
);

  item_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("item queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i)
    else $error("item queue read while empty");

endmodule

// ===== hw/rtl/dest_div.sv =====
// ----------------------------------------------------------------------------
// dest_div
// Restoring divider, 32-bit dividend by 40-bit divisor, one quotient bit per
// cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module dest_div import dest_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivW:0]    shifted;
  logic             last;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign last    = (cnt_q == CntW'(DataW - 1));

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = DivW'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hw/rtl/dest_back.sv =====
// ----------------------------------------------------------------------------
// dest_back
// Execution stage: keeps the per-side encoder state, runs the rpm division
// for edge items and builds the result register.
// ----------------------------------------------------------------------------
module dest_back import dest_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  fifo_stat_t fifo_stat_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  back_state_e      state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [DataW-1:0] now_q, now_d;
  logic [DataW-1:0] last_r_q, last_r_d, last_l_q, last_l_d;
  logic [DataW-1:0] per_r_q, per_r_d, per_l_q, per_l_d;
  logic [DataW-1:0] spd_r_q, spd_r_d, spd_l_q, spd_l_d;
  logic [DataW-1:0] cnt_r_q, cnt_r_d, cnt_l_q, cnt_l_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DataW-1:0] side_per;
  logic [DataW-1:0] since_r, since_l;
  logic [DataW:0]   cnt_sum;
  logic [DataW-1:0] avg;
  logic             is_edge;
  logic             out_free;

  dest_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign side_per = (kind_q == KIND_LEFT) ? per_l_q : per_r_q;
  assign since_r  = now_q - last_r_q;
  assign since_l  = now_q - last_l_q;
  assign cnt_sum  = {1'b0, cnt_r_q} + {1'b0, cnt_l_q};
  assign avg      = cnt_sum[DataW:1];
  assign is_edge  = (kind_q == KIND_RIGHT) || (kind_q == KIND_LEFT);

  always_comb begin
    state_d          = state_q;
    kind_d           = kind_q;
    now_d            = now_q;
    last_r_d         = last_r_q;
    last_l_d         = last_l_q;
    per_r_d          = per_r_q;
    per_l_d          = per_l_q;
    spd_r_d          = spd_r_q;
    spd_l_d          = spd_l_q;
    cnt_r_d          = cnt_r_q;
    cnt_l_d          = cnt_l_q;
    res_d            = res_q;
    out_valid_d      = out_valid_q & out_stall_i;
    pop_o            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cfg_i.ticks_per_minute;
    div_req.divisor  = DivW'(side_per) * DivW'(cfg_i.pulses_per_rev);

    case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o  = 1'b1;
          kind_d = item_i.kind;
          now_d  = item_i.timestamp;
          case (item_i.kind)
            KIND_RIGHT: begin
              per_r_d  = item_i.timestamp - last_r_q;
              last_r_d = item_i.timestamp;
              cnt_r_d  = cnt_r_q + 1'b1;
              state_d  = BK_MUL;
            end
            KIND_LEFT: begin
              per_l_d  = item_i.timestamp - last_l_q;
              last_l_d = item_i.timestamp;
              cnt_l_d  = cnt_l_q + 1'b1;
              state_d  = BK_MUL;
            end
            KIND_RESTART: begin
              cnt_r_d = '0;
              cnt_l_d = '0;
              state_d = BK_EMIT;
            end
            default: begin
              state_d = BK_EMIT;
            end
          endcase
        end
      end
      BK_MUL: begin
        div_req.start = 1'b1;
        state_d       = BK_DIV;
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          if (kind_q == KIND_LEFT) begin
            spd_l_d = div_rsp.quotient;
          end else begin
            spd_r_d = div_rsp.quotient;
          end
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          res_d.period_right   = per_r_q;
          res_d.period_left    = per_l_q;
          res_d.rpm_right      = (since_r > cfg_i.stall_limit) ? '0 : spd_r_q;
          res_d.rpm_left       = (since_l > cfg_i.stall_limit) ? '0 : spd_l_q;
          res_d.tick_average   = avg;
          res_d.target_reached = is_edge && (avg > cfg_i.target_ticks);
          out_valid_d          = 1'b1;
          state_d              = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      last_r_q    <= '0;
      last_l_q    <= '0;
      per_r_q     <= '0;
      per_l_q     <= '0;
      spd_r_q     <= '0;
      spd_l_q     <= '0;
      cnt_r_q     <= '0;
      cnt_l_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_r_q    <= last_r_d;
      last_l_q    <= last_l_d;
      per_r_q     <= per_r_d;
      per_l_q     <= per_l_d;
      spd_r_q     <= spd_r_d;
      spd_l_q     <= spd_l_d;
      cnt_r_q     <= cnt_r_d;
      cnt_l_q     <= cnt_l_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    now_q  <= now_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MUL) |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == BK_DIV))
    else $error("division finished outside the divide state");

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT && out_free && kind_q == KIND_RESTART)
      |=> (out_valid_q && res_q.tick_average == '0 && !res_q.target_reached))
    else $error("restart result shows stale counts");

endmodule

// ===== hw/rtl/dual_encoder_speed_and_tick_target.sv =====
// ----------------------------------------------------------------------------
// dual_encoder_speed_and_tick_target
// Two-wheel encoder period and rpm meter with an edge count target flag.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i/in_stall_o   action_i, timestamp_i
//   result   out        out_valid_o/out_stall_i period/rpm/average/target
//   config   in         psel/penable/pwrite     paddr, pwdata, prdata
//
// an edge item goes from transfer to result through the input register, the
// queue, the pop, the multiply state that starts the divider, the restoring
// divider steps, one per quotient bit, the divider done and the emit state
// a query or restart item goes from the pop straight to the emit state
// reset clears the control, config and per-side encoder state at once, no clearing pass
// a two entry queue lets inputs be taken while a division runs; a stalled
// result holds the execution stage in its emit cycle
// ----------------------------------------------------------------------------
module dual_encoder_speed_and_tick_target import dest_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [DataW-1:0] timestamp_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] period_right_o,
  output logic [DataW-1:0] period_left_o,
  output logic [DataW-1:0] rpm_right_o,
  output logic [DataW-1:0] rpm_left_o,
  output logic [DataW-1:0] tick_average_o,
  output logic             target_reached_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam logic [1:0] RegTarget = 2'd0;
  localparam logic [1:0] RegStall  = 2'd1;
  localparam logic [1:0] RegTpm    = 2'd2;
  localparam logic [1:0] RegPpr    = 2'd3;

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push, pop;
  item_t      push_item, pop_item;
  fifo_stat_t fifo_stat;
  result_t    res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegTarget: cfg_d.target_ticks     = pwdata;
        RegStall:  cfg_d.stall_limit      = pwdata;
        RegTpm:    cfg_d.ticks_per_minute = pwdata;
        RegPpr:    cfg_d.pulses_per_rev   = pwdata[PprW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTarget: prdata = cfg_q.target_ticks;
      RegStall:  prdata = cfg_q.stall_limit;
      RegTpm:    prdata = cfg_q.ticks_per_minute;
      RegPpr:    prdata = DataW'(cfg_q.pulses_per_rev);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_ticks     <= TargetTicksRst;
      cfg_q.stall_limit      <= StallLimitRst;
      cfg_q.ticks_per_minute <= TicksPerMinuteRst;
      cfg_q.pulses_per_rev   <= PulsesPerRevRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dest_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .timestamp_i (timestamp_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  dest_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (fifo_stat)
  );

  dest_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_stat_i (fifo_stat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign period_right_o   = res.period_right;
  assign period_left_o    = res.period_left;
  assign rpm_right_o      = res.rpm_right;
  assign rpm_left_o       = res.rpm_left;
  assign tick_average_o   = res.tick_average;
  assign target_reached_o = res.target_reached;

endmodule

// ===== sim/tb_dual_encoder_speed_and_tick_target.sv =====
// ----------------------------------------------------------------------------
// tb_dual_encoder_speed_and_tick_target
// Self-checking bench for the dual encoder period, rpm and tick target block.
// Edge, query and restart items are driven with random gaps and result stalls.
// A local status model predicts each result, and results are compared field
// by field in order. Registers are set over APB between phases, including
// their extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_encoder_speed_and_tick_target;
  import dest_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems = 210;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_STALL  = 2'd1,
    REG_TPM    = 2'd2,
    REG_PPR    = 2'd3
  } reg_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       action_i = KIND_QUERY;
  logic [DataW-1:0] timestamp_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [DataW-1:0] period_right_o;
  logic [DataW-1:0] period_left_o;
  logic [DataW-1:0] rpm_right_o;
  logic [DataW-1:0] rpm_left_o;
  logic [DataW-1:0] tick_average_o;
  logic             target_reached_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  dual_encoder_speed_and_tick_target u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .period_right_o   (period_right_o),
    .period_left_o    (period_left_o),
    .rpm_right_o      (rpm_right_o),
    .rpm_left_o       (rpm_left_o),
    .tick_average_o   (tick_average_o),
    .target_reached_o (target_reached_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow registers and wheel state, index 0 right, 1 left
  logic [DataW-1:0] cfg_target;
  logic [DataW-1:0] cfg_stall;
  logic [DataW-1:0] cfg_tpm;
  logic [PprW-1:0]  cfg_ppr;
  logic [DataW-1:0] edge_time [2];
  logic [DataW-1:0] period_meas [2];
  logic [DataW-1:0] speed_meas [2];
  logic [DataW-1:0] edge_cnt [2];

  result_t status_q [$];
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_gap = 0;
  int rx_hold = 0;
  logic [DataW-1:0] timer_now = '0;

  function automatic logic [DataW-1:0] shown_rpm(logic [DataW-1:0] ts, int s);
    return ((ts - edge_time[s]) > cfg_stall) ? '0 : speed_meas[s];
  endfunction

  function automatic result_t encoder_status(kind_e kind, logic [DataW-1:0] ts);
    result_t r;
    logic [63:0] divisor;
    logic [DataW:0] sum;
    bit is_edge;
    int s;
    is_edge = (kind == KIND_RIGHT) || (kind == KIND_LEFT);
    s = (kind == KIND_LEFT) ? 1 : 0;
    if (is_edge) begin
      period_meas[s] = ts - edge_time[s];
      divisor = 64'(period_meas[s]) * 64'(cfg_ppr);
      speed_meas[s] = (divisor == 0) ? '1 : DataW'(64'(cfg_tpm) / divisor);
      edge_time[s] = ts;
      edge_cnt[s] = edge_cnt[s] + 1;
    end else if (kind == KIND_RESTART) begin
      edge_cnt[0] = '0;
      edge_cnt[1] = '0;
    end
    sum = {1'b0, edge_cnt[0]} + {1'b0, edge_cnt[1]};
    r.period_right = period_meas[0];
    r.period_left = period_meas[1];
    r.rpm_right = shown_rpm(ts, 0);
    r.rpm_left = shown_rpm(ts, 1);
    r.tick_average = sum[DataW:1];
    r.target_reached = is_edge && (sum[DataW:1] > cfg_target);
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result check first, then prediction of any item taken at the same edge
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_gap = rx_idle_en ? $urandom_range(0, 18) : 0;
      if (status_q.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
      end else begin
        exp_r = status_q.pop_front();
        check_field("period_right", exp_r.period_right, period_right_o);
        check_field("period_left", exp_r.period_left, period_left_o);
        check_field("rpm_right", exp_r.rpm_right, rpm_right_o);
        check_field("rpm_left", exp_r.rpm_left, rpm_left_o);
        check_field("tick_average", exp_r.tick_average, tick_average_o);
        check_field("target_reached", DataW'(exp_r.target_reached),
                    DataW'(target_reached_o));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      status_q.push_back(encoder_status(kind_e'(action_i), timestamp_i));
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // leaves valid high after the transfer; wait_drained lowers it
  task automatic send_item(kind_e kind, logic [DataW-1:0] ts);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i <= kind;
    timestamp_i <= ts;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, reg_e idx, logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write, update the shadow copy, then read back
  task automatic write_reg(reg_e idx, logic [DataW-1:0] v);
    logic [DataW-1:0] rd;
    logic [DataW-1:0] exp_v;
    apb_access(1'b1, idx, v, rd);
    case (idx)
      REG_TARGET: cfg_target = v;
      REG_STALL:  cfg_stall = v;
      REG_TPM:    cfg_tpm = v;
      default:    cfg_ppr = v[PprW-1:0];
    endcase
    exp_v = (idx == REG_PPR) ? DataW'(v[PprW-1:0]) : v;
    apb_access(1'b0, idx, '0, rd);
    check_field("prdata", exp_v, rd);
  endtask

  task automatic set_config(logic [DataW-1:0] target, logic [DataW-1:0] stall,
                            logic [DataW-1:0] tpm, logic [DataW-1:0] ppr);
    write_reg(REG_TARGET, target);
    write_reg(REG_STALL, stall);
    write_reg(REG_TPM, tpm);
    write_reg(REG_PPR, ppr);
  endtask

  task automatic test_reset_defaults();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_item(KIND_QUERY, 32'd0);
    // first edge at time zero: zero period saturates the rpm
    send_item(KIND_RIGHT, 32'd0);
    send_item(KIND_LEFT, 32'd85714);
    send_item(KIND_RIGHT, 32'hFFFF_FFFF);
    // timer wrap on the next right edge
    send_item(KIND_RIGHT, 32'd5);
    send_item(KIND_QUERY, 32'd6000005);
    send_item(KIND_QUERY, 32'd6000006);
    send_item(KIND_QUERY, 32'd85714 + 32'd6000001);
    send_item(KIND_RESTART, 32'hFFFF_FFFF);
    send_item(KIND_LEFT, 32'd171428);
    send_item(KIND_RIGHT, 32'd171428);
    send_item(KIND_QUERY, 32'hAAAA_5555);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_RIGHT, 32'd1000);
    send_item(KIND_LEFT, 32'd1001);
    send_item(KIND_QUERY, 32'd1001);
    send_item(KIND_QUERY, 32'd1002);
    wait_drained();
    // zero pulses per rev makes every divisor zero
    set_config(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FF00);
    send_item(KIND_RIGHT, 32'h8000_0000);
    send_item(KIND_LEFT, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 32'h5555_AAAA);
    wait_drained();
    set_config(32'd1, 32'd100, 32'd1, 32'd1);
    send_item(KIND_RIGHT, 32'h8000_0001);
    send_item(KIND_LEFT, 32'h8000_0001);
    send_item(KIND_RIGHT, 32'h8000_0002);
    send_item(KIND_RESTART, 32'h8000_0003);
    send_item(KIND_LEFT, 32'h8000_0004);
    wait_drained();
  endtask

  task automatic test_target_crossing();
    int i;
    set_config(32'd3, 32'd6000000, 32'd2400000000, 32'd28);
    for (i = 0; i < 10; i++) begin
      timer_now += 32'd90000;
      send_item(kind_e'((i % 2) ? KIND_LEFT : KIND_RIGHT), timer_now);
    end
    send_item(KIND_QUERY, timer_now);
    wait_drained();
  endtask

  task automatic test_result_backpressure();
    int i;
    tx_idle_en = 1'b0;
    @(posedge clk_i);
    rx_hold = 400;
    for (i = 0; i < 30; i++) begin
      timer_now += $urandom_range(0, 5000);
      send_item(kind_e'($urandom_range(0, 3)), timer_now);
    end
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    int i;
    int pick;
    int unsigned step_max;
    logic [DataW-1:0] ts;
    kind_e kind;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: step_max = 30;
        1: step_max = 1000;
        2: step_max = 100000;
        default: step_max = 50000000;
      endcase
      timer_now = $urandom();
      set_config((phase == 7) ? 32'hFFFF_FFFF : $urandom_range(0, 30),
                 step_max * $urandom_range(1, 4),
                 (phase == 6) ? 32'hFFFF_FFFF : ($urandom() | 32'd1),
                 {24'($urandom_range(0, 255)), 8'($urandom_range(1, 255))});
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 39);
        if (pick < 15) kind = KIND_RIGHT;
        else if (pick < 30) kind = KIND_LEFT;
        else if (pick < 39) kind = KIND_QUERY;
        else kind = KIND_RESTART;
        // mostly a running timer, now and then an arbitrary stamp
        if ($urandom_range(0, 9) == 0) begin
          ts = $urandom();
        end else begin
          timer_now += $urandom_range(0, step_max);
          ts = timer_now;
        end
        send_item(kind, ts);
      end
      wait_drained();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    cfg_target = TargetTicksRst;
    cfg_stall = StallLimitRst;
    cfg_tpm = TicksPerMinuteRst;
    cfg_ppr = PulsesPerRevRst;
    for (int s = 0; s < 2; s++) begin
      edge_time[s] = '0;
      period_meas[s] = '0;
      speed_meas[s] = '0;
      edge_cnt[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_target_crossing();
    test_result_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (status_q.size() != 0) begin
      $error("%0d results never arrived", status_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
